/* design/aas_pkg.sv */
// Shared types, constants and the exponential table for the annealing acceptance block.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package aas_pkg;

	localparam int MAX_POINTS      = 16;
	localparam int PIDX_W          = $clog2(MAX_POINTS);
	localparam int CNT_W           = $clog2(MAX_POINTS + 1);
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);

	localparam logic [63:0] LN2_Q32   = 64'd2977044472;
	localparam logic [31:0] LOG2E_Q16 = 32'd94548;
	localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
	localparam int          X_W       = 22;
	localparam logic [X_W-1:0] X_SAT  = X_W'(32'd32 << 16);
	localparam int          STEP_W    = 7;
	localparam logic [STEP_W-1:0] INTERP_STEPS = STEP_W'(32);
	localparam logic [STEP_W-1:0] RATIO_STEPS  = STEP_W'(48);

	typedef enum logic [1:0] {
		KIND_CAND  = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_START = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic {
		CFG_END_PROGRESS = 1'b0,
		CFG_STEP_COUNT   = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL_I,
		ST_DIV_I_GO,
		ST_DIV_I_WAIT,
		ST_DELTA,
		ST_DIV_R_WAIT,
		ST_MUL_Y,
		ST_EXPO,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_ctl_t;

	typedef struct packed {
		logic              we;
		logic [PIDX_W-1:0] idx;
		logic [31:0]       pbegin;
		logic [31:0]       ptemp;
	} sched_wr_t;

	typedef logic [32:0] exp_rom_t [EXP_TABLE_DEPTH];

	function automatic logic [32:0] exp_neg_q32(input logic [63:0] t);
		logic [63:0] sum;
		logic [63:0] term;
		sum  = 64'(ONE_Q32);
		term = 64'(ONE_Q32);
		for (int i = 1; i <= 24; i++) begin
			term = ((term * t) >> 32) / 64'(i);
			if ((i % 2) == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		return (sum > 64'(ONE_Q32)) ? ONE_Q32 : sum[32:0];
	endfunction

	function automatic exp_rom_t build_exp_rom();
		exp_rom_t rom;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			rom[k] = exp_neg_q32((64'(k) * LN2_Q32) / EXP_TABLE_DEPTH);
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

/* design/aas_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by interpolation and ratio.
// Depends on aas_pkg for the control struct.
`default_nettype none

module aas_divider (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire aas_pkg::div_ctl_t   ctl,
	input  wire logic [31:0]         rem_init,
	input  wire logic [63:0]         dividend,
	input  wire logic [31:0]         divisor,
	output logic                     done,
	output logic [63:0]              quotient
);

	logic [31:0]                  rem_q;
	logic [63:0]                  quo_q;
	logic [31:0]                  div_q;
	logic [aas_pkg::STEP_W-1:0]   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [32:0]                  trial;
	logic                         fits;

	assign trial = {rem_q, quo_q[63]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == aas_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= rem_init;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* design/aas_schedule.sv */
// Temperature schedule store: begin progress and temperature of each point.
// Depends on aas_pkg for the write struct and the point count.
`default_nettype none

module aas_schedule (
	input  wire logic                        clk,
	input  wire aas_pkg::sched_wr_t          wr,
	input  wire logic [aas_pkg::PIDX_W-1:0]  rd_idx,
	output logic [31:0]                      rd_begin,
	output logic [31:0]                      rd_temp
);

	logic [31:0] begin_mem [aas_pkg::MAX_POINTS];
	logic [31:0] temp_mem  [aas_pkg::MAX_POINTS];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			begin_mem[wr.idx] <= wr.pbegin;
			temp_mem[wr.idx]  <= wr.ptemp;
		end
	end

	assign rd_begin = begin_mem[rd_idx];
	assign rd_temp  = temp_mem[rd_idx];

endmodule

`default_nettype wire

/* design/annealing_acceptance_scheduler_core.sv */
// Top level of the annealing acceptance block: sequencer, shared multiplier and output register.
// Depends on aas_pkg, aas_schedule and aas_divider.
// Load, start, no-op and ignored items go from idle straight to the finish state. A candidate
// passes through a scan of the schedule points, the delta step, the decide step and the finish
// state. The interpolation multiply and division are added when the progress lies between two
// points, and the ratio division, multiply and exponential when the energy rises at a nonzero
// temperature; both divisions use the shared one-bit-per-cycle divider. One item is
// worked on at a time, and the next item is taken while the previous result still waits in the
// output register.
`default_nettype none

module annealing_acceptance_scheduler_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic               cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic [3:0]         point_index,
	input  wire logic [31:0]        point_begin,
	input  wire logic [31:0]        point_temperature,
	input  wire logic signed [31:0] candidate_energy,
	input  wire logic [31:0]        random_fraction,
	input  wire logic [31:0]        start_progress,
	input  wire logic signed [31:0] start_energy,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    accepted,
	output logic signed [31:0]      held_energy,
	output logic [31:0]             used_temperature,
	output logic [31:0]             progress_now,
	output logic                    run_done
);

	aas_pkg::state_t state_q, state_d;

	logic [31:0]                 end_q;
	logic [4:0]                  step_q;
	logic [31:0]                 prog_q;
	logic signed [31:0]          energy_q;
	logic signed [31:0]          cand_q;
	logic [31:0]                 rand_q;
	logic [aas_pkg::CNT_W-1:0]   idx_q;
	logic [aas_pkg::CNT_W-1:0]   cnt;
	logic [31:0]                 bl_q, tl_q, br_q, tr_q;
	logic [31:0]                 temp_q;
	logic                        up_q;
	logic [63:0]                 prod_q;
	logic [aas_pkg::X_W-1:0]     x_q;
	logic [32:0]                 prob_q;
	logic                        acc_q;
	logic                        out_valid_q;

	logic                        accept_in;
	logic                        out_load;
	logic [31:0]                 rd_begin, rd_temp;
	aas_pkg::sched_wr_t          sched_wr;
	aas_pkg::div_ctl_t           div_ctl;
	logic [31:0]                 div_rem;
	logic [63:0]                 div_dividend;
	logic [31:0]                 div_divisor;
	logic                        div_done;
	logic [63:0]                 div_quo;
	logic [31:0]                 mul_a, mul_b;
	logic [63:0]                 mul_p;
	logic [32:0]                 delta;
	logic                        delta_pos;
	logic [31:0]                 exp_n;
	logic [aas_pkg::EXP_IDX_W-1:0] exp_idx;

	assign in_ready  = (state_q == aas_pkg::ST_IDLE);
	assign accept_in = in_valid && in_ready;
	assign out_load  = (state_q == aas_pkg::ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		if (step_q == 5'd0) begin
			cnt = aas_pkg::CNT_W'(1);
		end else if (32'(step_q) > aas_pkg::MAX_POINTS) begin
			cnt = aas_pkg::CNT_W'(aas_pkg::MAX_POINTS);
		end else begin
			cnt = aas_pkg::CNT_W'(step_q);
		end
	end

	assign sched_wr.we     = accept_in && (aas_pkg::kind_t'(kind) == aas_pkg::KIND_LOAD)
		&& (32'(point_index) < aas_pkg::MAX_POINTS);
	assign sched_wr.idx    = aas_pkg::PIDX_W'(point_index);
	assign sched_wr.pbegin = point_begin;
	assign sched_wr.ptemp  = point_temperature;

	aas_schedule u_schedule (
		.clk      (clk),
		.wr       (sched_wr),
		.rd_idx   (idx_q[aas_pkg::PIDX_W-1:0]),
		.rd_begin (rd_begin),
		.rd_temp  (rd_temp)
	);

	assign delta     = {cand_q[31], cand_q} - {energy_q[31], energy_q};
	assign delta_pos = !delta[32] && (delta != 33'd0);

	always_comb begin
		div_ctl.start = 1'b0;
		div_ctl.steps = aas_pkg::INTERP_STEPS;
		div_rem       = prod_q[63:32];
		div_dividend  = {prod_q[31:0], 32'd0};
		div_divisor   = br_q - bl_q;
		if (state_q == aas_pkg::ST_DIV_I_GO) begin
			div_ctl.start = 1'b1;
		end else if (state_q == aas_pkg::ST_DELTA) begin
			div_ctl.start = delta_pos && (temp_q != 32'd0);
			div_ctl.steps = aas_pkg::RATIO_STEPS;
			div_rem       = 32'd0;
			div_dividend  = {delta[31:0], 32'd0};
			div_divisor   = temp_q;
		end
	end

	aas_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.rem_init (div_rem),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		if (state_q == aas_pkg::ST_MUL_Y) begin
			mul_a = 32'(x_q);
			mul_b = aas_pkg::LOG2E_Q16;
		end else begin
			mul_a = up_q ? tr_q - tl_q : tl_q - tr_q;
			mul_b = prog_q - bl_q;
		end
	end

	assign mul_p   = 64'(mul_a) * 64'(mul_b);
	assign exp_n   = prod_q[63:32];
	assign exp_idx = prod_q[31 -: aas_pkg::EXP_IDX_W];

	always_comb begin
		state_d = state_q;
		case (state_q)
			aas_pkg::ST_IDLE: begin
				if (accept_in) begin
					if (aas_pkg::kind_t'(kind) == aas_pkg::KIND_CAND && prog_q < end_q) begin
						state_d = aas_pkg::ST_SEARCH;
					end else begin
						state_d = aas_pkg::ST_FINISH;
					end
				end
			end
			aas_pkg::ST_SEARCH: begin
				if (idx_q == cnt) begin
					state_d = aas_pkg::ST_DELTA;
				end else if (rd_begin > prog_q) begin
					state_d = (idx_q == '0) ? aas_pkg::ST_DELTA : aas_pkg::ST_MUL_I;
				end
			end
			aas_pkg::ST_MUL_I:      state_d = aas_pkg::ST_DIV_I_GO;
			aas_pkg::ST_DIV_I_GO:   state_d = aas_pkg::ST_DIV_I_WAIT;
			aas_pkg::ST_DIV_I_WAIT: if (div_done) state_d = aas_pkg::ST_DELTA;
			aas_pkg::ST_DELTA: begin
				state_d = div_ctl.start ? aas_pkg::ST_DIV_R_WAIT : aas_pkg::ST_DECIDE;
			end
			aas_pkg::ST_DIV_R_WAIT: if (div_done) state_d = aas_pkg::ST_MUL_Y;
			aas_pkg::ST_MUL_Y:      state_d = aas_pkg::ST_EXPO;
			aas_pkg::ST_EXPO:       state_d = aas_pkg::ST_DECIDE;
			aas_pkg::ST_DECIDE:     state_d = aas_pkg::ST_FINISH;
			aas_pkg::ST_FINISH:     if (out_load) state_d = aas_pkg::ST_IDLE;
			default:                state_d = aas_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aas_pkg::ST_IDLE;
			end_q       <= '0;
			step_q      <= 5'd1;
			prog_q      <= '0;
			energy_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				if (aas_pkg::cfg_reg_t'(cfg_index) == aas_pkg::CFG_END_PROGRESS) begin
					end_q <= cfg_data;
				end else begin
					step_q <= cfg_data[4:0];
				end
			end
			if (accept_in && aas_pkg::kind_t'(kind) == aas_pkg::KIND_START) begin
				prog_q   <= start_progress;
				energy_q <= start_energy;
			end
			if (state_q == aas_pkg::ST_DECIDE) begin
				prog_q <= prog_q + 32'd1;
				if (prob_q >= {1'b0, rand_q}) begin
					energy_q <= cand_q;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			aas_pkg::ST_IDLE: begin
				cand_q <= candidate_energy;
				rand_q <= random_fraction;
				idx_q  <= '0;
				temp_q <= '0;
				acc_q  <= 1'b0;
			end
			aas_pkg::ST_SEARCH: begin
				if (idx_q == cnt) begin
					temp_q <= tl_q;
				end else if (rd_begin <= prog_q) begin
					bl_q  <= rd_begin;
					tl_q  <= rd_temp;
					idx_q <= idx_q + 1'b1;
				end else begin
					temp_q <= rd_temp;
					br_q   <= rd_begin;
					tr_q   <= rd_temp;
					up_q   <= rd_temp >= tl_q;
				end
			end
			aas_pkg::ST_MUL_I: prod_q <= mul_p;
			aas_pkg::ST_DIV_I_WAIT: begin
				if (div_done) begin
					temp_q <= up_q ? tl_q + div_quo[31:0] : tl_q - div_quo[31:0];
				end
			end
			aas_pkg::ST_DELTA: begin
				if (!delta_pos) begin
					prob_q <= aas_pkg::ONE_Q32;
				end else begin
					prob_q <= '0;
				end
			end
			aas_pkg::ST_DIV_R_WAIT: begin
				if (div_done) begin
					x_q <= (div_quo[47:0] > 48'(aas_pkg::X_SAT)) ? aas_pkg::X_SAT
						: div_quo[aas_pkg::X_W-1:0];
				end
			end
			aas_pkg::ST_MUL_Y: prod_q <= mul_p;
			aas_pkg::ST_EXPO: begin
				if (exp_n >= 32'd33) begin
					prob_q <= '0;
				end else begin
					prob_q <= aas_pkg::EXP_ROM[exp_idx] >> exp_n[5:0];
				end
			end
			aas_pkg::ST_DECIDE: acc_q <= prob_q >= {1'b0, rand_q};
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			accepted         <= acc_q;
			held_energy      <= energy_q;
			used_temperature <= temp_q;
			progress_now     <= prog_q;
			run_done         <= prog_q >= end_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
